// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the 3x3 matrix inverse.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent assertion on the house clock and reset names.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/m3i_pkg.sv =====
// Shared widths and types for the 3x3 matrix inverse.
// No dependencies; used by m3i_divider and matrix3x3_inverse.
`timescale 1ns / 1ps

package m3i_pkg;

  // Matrix entries and result fields are Q16.16 words.
  localparam int unsigned EntW   = 32;
  // Number of matrix entries, and of divider lanes.
  localparam int unsigned NumEnt = 9;
  // Quotient bits produced by the divider, one per stage.
  localparam int unsigned QuoW   = 32;
  // Divisor width: holds twice the determinant magnitude.
  localparam int unsigned DenW   = 98;

  typedef logic signed [EntW-1:0] ent_t;
  typedef logic [DenW-1:0]        den_t;
  typedef logic [QuoW-1:0]        quo_t;

endpackage

// ===== hdl/m3i_divider.sv =====
// Pipelined restoring divider, nine lanes sharing one divisor.
// Depends on m3i_pkg; one quotient bit is resolved per register stage.
`timescale 1ns / 1ps

module m3i_divider (
  input  logic           clk_i,
  input  logic           en_i,
  input  m3i_pkg::den_t  rem_i [m3i_pkg::NumEnt],
  input  m3i_pkg::den_t  den_i,
  input  m3i_pkg::quo_t  low_i,
  output m3i_pkg::quo_t  quo_o [m3i_pkg::NumEnt]
);

  localparam int unsigned Steps = m3i_pkg::QuoW;
  localparam int unsigned Lanes = m3i_pkg::NumEnt;
  localparam int unsigned DenW  = m3i_pkg::DenW;

  // Partial remainders, divisor and dividend low bits between stages.
  m3i_pkg::den_t rem_q [Steps-1][Lanes];
  m3i_pkg::den_t den_q [Steps-1];
  m3i_pkg::quo_t low_q [Steps-1];
  m3i_pkg::quo_t quo_q [Steps][Lanes];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    m3i_pkg::den_t rem_in [Lanes];
    m3i_pkg::quo_t quo_in [Lanes];
    m3i_pkg::den_t den_in;
    m3i_pkg::quo_t low_in;

    // Stage inputs come from the ports or from the previous stage.
    if (k == 0) begin : g_first
      assign den_in = den_i;
      assign low_in = low_i;
      for (genvar l = 0; l < Lanes; l++) begin : g_in
        assign rem_in[l] = rem_i[l];
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign den_in = den_q[k-1];
      assign low_in = low_q[k-1];
      for (genvar l = 0; l < Lanes; l++) begin : g_in
        assign rem_in[l] = rem_q[k-1][l];
        assign quo_in[l] = quo_q[k-1][l];
      end
    end

    // The shared operands travel along with the remainders.
    if (k < Steps - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[k] <= den_in;
          low_q[k] <= low_in;
        end
      end
    end

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic [DenW:0] trial;
      logic          fit;

      // Bring down the next dividend bit and try one subtraction.
      assign trial = {rem_in[l], low_in[Steps-1-k]};
      assign fit   = (trial >= {1'b0, den_in});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[k][l] <= {quo_in[l][Steps-2:0], fit};
        end
      end

      if (k < Steps - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[k][l] <= fit ? DenW'(trial - {1'b0, den_in}) : trial[DenW-1:0];
          end
        end
      end
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_out
    assign quo_o[l] = quo_q[Steps-1][l];
  end

endmodule

// ===== hdl/matrix3x3_inverse.sv =====
// 3x3 matrix inverse by the adjugate in Q16.16, with a singular threshold.
// Throughput: one matrix per cycle while the output is not stalled; 7 arithmetic stages, then a 32-stage divider.
// The whole pipeline advances together whenever the output register is free or taken.
// Reset clears all valid bits and sets the singular threshold to 1 (2^-16).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix3x3_inverse (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row0_col0, row0_col1, row0_col2, row1_col0, ... row2_col2 (32 bits each)
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // inv_r0_c0, inv_r0_c1, ... inv_r2_c2, determinant (32 bits each)
  output logic [319:0] m_axis_tdata,
  // singular
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [30:0]  cfg_data_i
);

  localparam int unsigned EntW   = m3i_pkg::EntW;
  localparam int unsigned NumEnt = m3i_pkg::NumEnt;
  localparam int unsigned QuoW   = m3i_pkg::QuoW;
  localparam int unsigned DenW   = m3i_pkg::DenW;
  localparam int unsigned PrdW   = 2 * EntW;
  localparam int unsigned CofW   = PrdW + 1;
  localparam int unsigned PartW  = CofW;
  localparam int unsigned TermW  = 97;
  localparam int unsigned DetW   = TermW + 1;
  localparam int unsigned MagW   = DetW - 1;
  localparam int unsigned AmagW  = CofW;
  localparam int unsigned RndW   = DetW - QuoW;
  localparam int unsigned ThrW   = 31;
  localparam int unsigned PreStg = 7;

  localparam logic [EntW-1:0] MaxPos    = 32'h7FFF_FFFF;
  localparam logic [EntW-1:0] MinNeg    = 32'h8000_0000;
  localparam logic [DetW-1:0] RoundHalf = DetW'(1) << (QuoW - 1);

  // Cofactor k of the adjugate is m[A]*m[B] - m[C]*m[D], row-major indexes.
  localparam int CofA [NumEnt] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CofB [NumEnt] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CofC [NumEnt] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int CofD [NumEnt] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic               adv;
  logic [PreStg-1:0]  v_q;
  logic [QuoW-1:0]    ds_v_q;
  logic               mv_q;
  logic [ThrW-1:0]    thr_q;

  m3i_pkg::ent_t           m_in   [NumEnt];
  logic signed [PrdW-1:0]  pa_q   [NumEnt];
  logic signed [PrdW-1:0]  pb_q   [NumEnt];
  m3i_pkg::ent_t           r0a_q  [3];
  m3i_pkg::ent_t           r0b_q  [3];
  logic signed [CofW-1:0]  cof_q  [NumEnt];
  logic signed [CofW-1:0]  adj3_q [NumEnt];
  logic signed [CofW-1:0]  adj4_q [NumEnt];
  logic signed [CofW-1:0]  adj5_q [NumEnt];
  logic signed [PartW-1:0] plo_q  [3];
  logic signed [PartW-1:0] phi_q  [3];
  logic signed [TermW-1:0] term_q [3];
  logic signed [DetW-1:0]  det_q;
  logic                    dneg6_q;
  logic [MagW-1:0]         dmag6_q;
  logic [AmagW-1:0]        amag6_q [NumEnt];
  logic [NumEnt-1:0]       aneg6_q;
  m3i_pkg::den_t           rem7_q [NumEnt];
  m3i_pkg::den_t           den7_q;
  m3i_pkg::quo_t           low7_q;
  logic [NumEnt-1:0]       neg7_q;
  logic                    sing7_q;
  logic [EntW-1:0]         det7_q;
  logic [DetW-1:0]         dsum;
  logic [RndW-1:0]         drnd;
  logic [EntW-1:0]         det_field;
  logic [NumEnt-1:0]       ovf_d;
  m3i_pkg::quo_t           quo    [NumEnt];
  logic                    ds_sing_q [QuoW];
  logic [EntW-1:0]         ds_det_q  [QuoW];
  logic [NumEnt-1:0]       ds_neg_q  [QuoW];
  logic [NumEnt-1:0]       ds_ovf_q  [QuoW];
  logic [EntW-1:0]         inv_d     [NumEnt];
  logic [319:0]            out_data_q;
  logic                    out_sing_q;

  // The pipeline moves as one whenever the output register can take a result.
  assign adv           = !mv_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sing_q;
  assign cfg_ready_o   = 1'b1;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrW'(1);
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Valid bits travel with the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      ds_v_q <= '0;
      mv_q   <= 1'b0;
    end else if (adv) begin
      v_q    <= {v_q[PreStg-2:0], s_axis_tvalid};
      ds_v_q <= {ds_v_q[QuoW-2:0], v_q[PreStg-1]};
      mv_q   <= ds_v_q[QuoW-1];
    end
  end

  always_comb begin
    for (int i = 0; i < NumEnt; i++) begin
      m_in[i] = s_axis_tdata[i*EntW +: EntW];
    end
  end

  // Stages 1 to 5: products, cofactors, split products and the determinant.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumEnt; k++) begin
        pa_q[k]   <= m_in[CofA[k]] * m_in[CofB[k]];
        pb_q[k]   <= m_in[CofC[k]] * m_in[CofD[k]];
        cof_q[k]  <= CofW'(pa_q[k]) - CofW'(pb_q[k]);
        adj3_q[k] <= cof_q[k];
        adj4_q[k] <= adj3_q[k];
        adj5_q[k] <= adj4_q[k];
      end
      for (int j = 0; j < 3; j++) begin
        r0a_q[j]  <= m_in[j];
        r0b_q[j]  <= r0a_q[j];
        plo_q[j]  <= $signed({1'b0, cof_q[3*j][EntW-1:0]}) * r0b_q[j];
        phi_q[j]  <= $signed(cof_q[3*j][CofW-1:EntW]) * r0b_q[j];
        term_q[j] <= {phi_q[j][TermW-EntW-1:0], {EntW{1'b0}}} + TermW'(plo_q[j]);
      end
      det_q <= DetW'(term_q[0]) + DetW'(term_q[1]) + DetW'(term_q[2]);
    end
  end

  // Stage 6: magnitudes and signs of the determinant and the adjugate.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dneg6_q <= det_q[DetW-1];
      dmag6_q <= MagW'(det_q[DetW-1] ? -det_q : det_q);
      for (int k = 0; k < NumEnt; k++) begin
        aneg6_q[k] <= adj5_q[k][CofW-1];
        amag6_q[k] <= AmagW'(adj5_q[k][CofW-1] ? -adj5_q[k] : adj5_q[k]);
      end
    end
  end

  // Determinant rounded half away from zero to Q16.16 and saturated.
  always_comb begin
    dsum = {1'b0, dmag6_q} + RoundHalf;
    drnd = dsum[DetW-1:QuoW];
    if (!dneg6_q) begin
      det_field = (drnd > RndW'(MaxPos)) ? MaxPos : drnd[EntW-1:0];
    end else begin
      det_field = (drnd > RndW'(MinNeg)) ? MinNeg : -drnd[EntW-1:0];
    end
  end

  // Stage 7: divider operands, singular test and determinant field.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumEnt; k++) begin
        rem7_q[k] <= DenW'({amag6_q[k], 1'b0}) + DenW'(dmag6_q[MagW-1:QuoW]);
      end
      den7_q  <= {dmag6_q, 1'b0};
      low7_q  <= dmag6_q[QuoW-1:0];
      neg7_q  <= aneg6_q ^ {NumEnt{dneg6_q}};
      sing7_q <= (dmag6_q == '0) || (dmag6_q < MagW'({thr_q, {QuoW{1'b0}}}));
      det7_q  <= det_field;
    end
  end

  // A quotient of 2^32 or more is caught up front and saturates later.
  always_comb begin
    for (int k = 0; k < NumEnt; k++) begin
      ovf_d[k] = (rem7_q[k] >= den7_q);
    end
  end

  m3i_divider u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .rem_i (rem7_q),
    .den_i (den7_q),
    .low_i (low7_q),
    .quo_o (quo)
  );

  // Side information delayed alongside the divider.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ds_sing_q[0] <= sing7_q;
      ds_det_q[0]  <= det7_q;
      ds_neg_q[0]  <= neg7_q;
      ds_ovf_q[0]  <= ovf_d;
      for (int i = 1; i < QuoW; i++) begin
        ds_sing_q[i] <= ds_sing_q[i-1];
        ds_det_q[i]  <= ds_det_q[i-1];
        ds_neg_q[i]  <= ds_neg_q[i-1];
        ds_ovf_q[i]  <= ds_ovf_q[i-1];
      end
    end
  end

  // Apply sign and saturation; a singular matrix gives all zeros.
  always_comb begin
    for (int l = 0; l < NumEnt; l++) begin
      if (ds_sing_q[QuoW-1]) begin
        inv_d[l] = '0;
      end else if (!ds_neg_q[QuoW-1][l]) begin
        inv_d[l] = (ds_ovf_q[QuoW-1][l] || quo[l][QuoW-1]) ? MaxPos : quo[l];
      end else begin
        inv_d[l] = (ds_ovf_q[QuoW-1][l] || (quo[l] > MinNeg)) ? MinNeg : -quo[l];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < NumEnt; l++) begin
        out_data_q[l*EntW +: EntW] <= inv_d[l];
      end
      out_data_q[NumEnt*EntW +: EntW] <= ds_det_q[QuoW-1];
      out_sing_q <= ds_sing_q[QuoW-1];
    end
  end

  // A singular result never carries a nonzero inverse entry.
  `ASSERT_STD(a_sing_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[287:0] == '0, "singular result with nonzero inverse")
  // An accepted request always enters the first stage.
  `ASSERT_STD(a_accept_fill, s_axis_tvalid && s_axis_tready |=> v_q[0], "accepted request lost at entry")
  // A new result only appears when the divider delivered one.
  `ASSERT_STD(a_out_src, $rose(m_axis_tvalid) |-> $past(ds_v_q[QuoW-1]), "result without a source")

endmodule

// ===== tb/sv/matrix3x3_inverse_test.sv =====
// Self-checking testbench for the 3x3 matrix inverse stream block.
// Depends on the matrix3x3_inverse RTL. It predicts each result exactly with wide
// integers and checks it while both stream sides idle and stall at random.
`timescale 1ns / 1ps

module matrix3x3_inverse_test;

  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned Latency     = 40;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned RandomItems = 1680;
  localparam logic [31:0] One         = 32'h0001_0000;

  // Scoreboard: predicts the inverse of each accepted matrix and checks results in order.
  class inverse_scoreboard;
    logic [30:0]  threshold = 31'd1;
    logic [320:0] expected_q[$];
    int unsigned  errors = 0;
    int unsigned  checked = 0;
    int unsigned  singular_seen = 0;

    // Sign and magnitude to a saturated Q16.16 word.
    function automatic logic [31:0] saturate(bit neg, logic [127:0] mag);
      if (!neg) return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      if (mag > 128'h8000_0000) return 32'h8000_0000;
      return 32'(-mag[31:0]);
    endfunction

    function automatic void note_matrix(logic [287:0] mat);
      logic signed [127:0] m[9];
      logic signed [127:0] adj[9];
      logic signed [127:0] det;
      logic [127:0]        dmag, num, quot, thr;
      logic [319:0]        fields;
      bit                  sing;
      for (int i = 0; i < 9; i++) m[i] = $signed(mat[32*i +: 32]);
      // Adjugate, row-major, from the 2x2 cofactors.
      adj[0] = m[4] * m[8] - m[5] * m[7];
      adj[1] = m[2] * m[7] - m[1] * m[8];
      adj[2] = m[1] * m[5] - m[2] * m[4];
      adj[3] = m[5] * m[6] - m[3] * m[8];
      adj[4] = m[0] * m[8] - m[2] * m[6];
      adj[5] = m[2] * m[3] - m[0] * m[5];
      adj[6] = m[3] * m[7] - m[4] * m[6];
      adj[7] = m[1] * m[6] - m[0] * m[7];
      adj[8] = m[0] * m[4] - m[1] * m[3];
      det = adj[0] * m[0] + adj[3] * m[1] + adj[6] * m[2];
      dmag = (det < 0) ? -det : det;
      // Q48.48 to Q16.16, rounding half away from zero.
      fields[288 +: 32] = saturate(det < 0, (dmag + (128'd1 << 31)) >> 32);
      thr = {97'd0, threshold} << 32;
      sing = (dmag == 0) || (dmag < thr);
      for (int i = 0; i < 9; i++) begin
        if (sing) begin
          fields[32*i +: 32] = '0;
        end else begin
          num = ((adj[i] < 0) ? -adj[i] : adj[i]) << 32;
          quot = (2 * num + dmag) / (2 * dmag);
          fields[32*i +: 32] = saturate((adj[i] < 0) != (det < 0), quot);
        end
      end
      expected_q.push_back({sing, fields});
    endfunction

    function automatic void check_result(logic [319:0] data, logic user);
      string        names[10] = '{"inv_r0_c0", "inv_r0_c1", "inv_r0_c2", "inv_r1_c0",
                                  "inv_r1_c1", "inv_r1_c2", "inv_r2_c0", "inv_r2_c1",
                                  "inv_r2_c2", "determinant"};
      logic [320:0] exp_item;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: tdata=%h tuser=%b", data, user);
        errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      checked++;
      if (exp_item[320]) singular_seen++;
      for (int i = 0; i < 10; i++) begin
        if (data[32*i +: 32] !== exp_item[32*i +: 32]) begin
          $error("%s: expected %h, got %h", names[i], exp_item[32*i +: 32], data[32*i +: 32]);
          errors++;
        end
      end
      if (user !== exp_item[320]) begin
        $error("singular: expected %b, got %b", exp_item[320], user);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // row0_col0, row0_col1, ... row2_col2 (32 bits each)
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // inv_r0_c0, ... inv_r2_c2, determinant (32 bits each)
  logic [319:0] m_axis_tdata;
  // singular
  logic         m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [30:0]  cfg_data_i = '0;

  inverse_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off = 1'b0;
  int unsigned requests_taken = 0;
  int unsigned cfg_taken = 0;
  int unsigned cycles = 0;

  matrix3x3_inverse uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Handshake monitors: note requests, check results, count config writes.
  always @(posedge clk_i) begin
    cycles++;
    if (s_axis_tvalid && s_axis_tready) begin
      sb.note_matrix(s_axis_tdata);
      requests_taken++;
    end
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    if (cfg_valid_i && cfg_ready_o) begin
      sb.threshold = cfg_data_i;
      cfg_taken++;
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Must be entered at a falling edge; returns at the falling edge after acceptance.
  task automatic send_matrix(logic [287:0] mat);
    int unsigned taken_before;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = mat;
    taken_before = requests_taken;
    do @(negedge clk_i); while (requests_taken == taken_before);
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [30:0] value);
    int unsigned taken_before;
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    taken_before = cfg_taken;
    do @(negedge clk_i); while (cfg_taken == taken_before);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [287:0] diagonal(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [287:0] mat = '0;
    mat[0 +: 32] = a;
    mat[128 +: 32] = b;
    mat[256 +: 32] = c;
    return mat;
  endfunction

  // Random matrices: full-range noise, moderate-range, tiny, and rank-deficient.
  function automatic logic [287:0] random_matrix();
    logic [287:0] mat;
    int unsigned  kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      unique case (kind)
        0, 1: mat[32*i +: 32] = $urandom;
        2, 3, 4, 5: mat[32*i +: 32] = 32'($signed($urandom_range(1 << 19)) - (1 << 18));
        6, 7: mat[32*i +: 32] = 32'($signed($urandom_range(2047)) - 1024);
        default: mat[32*i +: 32] = $urandom;
      endcase
    end
    // Make row 2 a copy or a scaled copy of row 0 for singular cases.
    if (kind >= 8) begin
      for (int i = 0; i < 3; i++)
        mat[192 + 32*i +: 32] = (kind == 8) ? mat[32*i +: 32] : 32'(-mat[32*i +: 32]);
    end
    return mat;
  endfunction

  // Long receiver hold-off in the first phase with free-flowing input.
  initial begin
    wait (rst_ni);
    repeat (60) @(negedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(negedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    logic [30:0]  thresholds[4];
    int unsigned  idle_pcts[4];
    int unsigned  stall_pcts[4];
    logic [287:0] mat;
    thresholds = '{31'd1, 31'd0, 31'h7FFF_FFFF, 31'($urandom_range(1 << 20))};
    idle_pcts = '{0, 80, 0, 12};
    stall_pcts = '{0, 0, 80, 12};

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      write_threshold(thresholds[phase]);
      send_idle_pct = idle_pcts[phase];
      recv_stall_pct = stall_pcts[phase];
      // Directed corners, run under the first two thresholds.
      if (phase < 2) begin
        send_matrix(diagonal(One, One, One));
        send_matrix('0);
        send_matrix({9{32'h7FFF_FFFF}});
        send_matrix({9{32'h8000_0000}});
        send_matrix(diagonal(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_matrix(diagonal(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diagonal(32'd1, 32'd1, 32'd1));
        send_matrix(diagonal(32'd1, One, One));
        send_matrix(diagonal(32'd3, One, One));
        send_matrix(diagonal(32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000));
        send_matrix(diagonal(32'h0000_0001, 32'h0000_0100, 32'h0000_0100));
        mat = diagonal(One, One, One);
        mat[32 +: 32] = 32'hFFFF_FFFF;
        send_matrix(mat);
      end
      for (int n = 0; n < RandomItems / 4; n++) send_matrix(random_matrix());
      drain_pipeline();
    end

    $display("Checked %0d results (%0d singular) over 4 thresholds and idle patterns.",
             sb.checked, sb.singular_seen);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/m3i_pkg.sv
hdl/m3i_divider.sv
hdl/matrix3x3_inverse.sv
tb/sv/matrix3x3_inverse_test.sv
